FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sort engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/hse_pkg.sv
// Package of the sort engine: widths, defaults and the cell link types.
package hse_pkg;

  localparam int unsigned DataW          = 32;
  localparam int unsigned MaxItemsDefault = 64;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [DataW-1:0] x;
  } hse_ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic             displace;
    logic [DataW-1:0] value;
  } hse_link_t;

endpackage

FILE: rtl/heap_sort_engine.sv
// Sort engine: a chain of MAX_ITEMS cells keeps the loaded words in ascending order.
// Load: one word per cycle while busy_o is low, inserted when accepted unless full.
// Emit: after the word marked last, one result per cycle per held word, busy_o high.
// The first result appears in the cycle after the last word is accepted.
// The receiver cannot stall: each result word is on the ports for one cycle only.
// Reset clears the chain valid bits, the fill count and the overflow flag.
module heap_sort_engine #(
  parameter int unsigned MAX_ITEMS = hse_pkg::MaxItemsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [hse_pkg::DataW-1:0] value_i,
  input  logic                      is_last_i,
  output logic                      valid_o,
  output logic signed [hse_pkg::DataW-1:0] sorted_value_o,
  output logic                      is_last_res_o,
  output logic                      overflowed_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            accept;
  logic            full;

  hse_pkg::hse_ctrl_t ctrl;
  hse_pkg::hse_link_t links [MAX_ITEMS];
  hse_pkg::hse_link_t head_link;
  hse_pkg::hse_link_t tail_link;

  assign accept = start_i && (state_q == StLoad);
  assign full   = count_q == CntW'(MAX_ITEMS);

  // Broadcast insert and shift commands to the chain
  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = state_q == StEmit;
  assign ctrl.x     = value_i;

  // Head accepts any word, tail feeds empties in on a shift
  assign head_link.valid    = 1'b1;
  assign head_link.displace = 1'b0;
  assign head_link.value    = '0;
  assign tail_link.valid    = 1'b0;
  assign tail_link.displace = 1'b0;
  assign tail_link.value    = '0;

  // Build the row of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    hse_pkg::hse_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = head_link;
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_l = tail_link;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    hse_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left_l),
      .right_i(right_l),
      .link_o (links[i])
    );
  end

  // Sequence loading and emission
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (is_last_i) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          state_d = StLoad;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Drive the result word from the head cell
  assign busy_o         = state_q == StEmit;
  assign valid_o        = state_q == StEmit;
  assign sorted_value_o = $signed(links[0].value);
  assign is_last_res_o  = (state_q == StEmit) && (count_q == CntW'(1));
  assign overflowed_o   = (state_q == StEmit) && ovf_q;

  `ASSERT_CLK(a_head_valid, clk_i, rst_ni, valid_o |-> links[0].valid)
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(MAX_ITEMS))
  `ASSERT_CLK(a_last_ends, clk_i, rst_ni, (valid_o && is_last_res_o) |=> !busy_o)
  `ASSERT_CLK(a_last_starts, clk_i, rst_ni, (start_i && !busy_o && is_last_i) |=> valid_o)

endmodule

FILE: rtl/hse_cell.sv
// One cell of the sorted register chain: holds one word, inserts and shifts.
module hse_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hse_pkg::hse_ctrl_t ctrl_i,
  input  hse_pkg::hse_link_t left_i,
  input  hse_pkg::hse_link_t right_i,
  output hse_pkg::hse_link_t link_o
);

  logic                      valid_q, valid_d;
  logic [hse_pkg::DataW-1:0] value_q, value_d;
  logic                      x_below;

  // Incoming word is smaller than the held one (the valid bit is not looked at here)
  assign x_below = $signed(ctrl_i.x) < $signed(value_q);

  // Pick next contents: shift toward the head, or take part in an insert
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (ctrl_i.ins) begin
      if (left_i.displace) begin
        valid_d = 1'b1;
        value_d = left_i.value;
      end else if (left_i.valid && (!valid_q || x_below)) begin
        valid_d = 1'b1;
        value_d = ctrl_i.x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid    = valid_q;
  assign link_o.displace = valid_q && x_below;
  assign link_o.value    = value_q;

endmodule

FILE: bench/heap_sort_engine_tb.sv
// Self-checking testbench of the sort engine: directed sets, then random sets.
`timescale 1ns / 1ps

module heap_sort_engine_tb;

  localparam int unsigned DW       = hse_pkg::DataW;
  localparam int unsigned Capacity = hse_pkg::MaxItemsDefault;
  localparam int          TableLen = 22;
  localparam int          RandWords = 450;
  localparam int          MaxReports = 50;

  localparam logic signed [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};

  // One result word as it should leave the engine
  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 dropped;
  } sorted_word_t;

  // One row of the directed stimulus; typed rows carry their own expectation
  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 typed;
    logic signed [DW-1:0] exp_value;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic signed [DW-1:0] value_i = '0;
  logic                 is_last_i = 1'b0;
  logic                 valid_o;
  logic signed [DW-1:0] sorted_value_o;
  logic                 is_last_res_o;
  logic                 overflowed_o;

  // Typed expectation that goes along with the word on the bus
  logic                 typed_r = 1'b0;
  logic signed [DW-1:0] typed_value_r = '0;

  // Predictor state: the set being loaded and its drop flag
  logic signed [DW-1:0] word_store [Capacity];
  logic [6:0]           fill_cnt = '0;
  logic                 drop_seen = 1'b0;

  sorted_word_t sorted_q [$];

  bit idle_on = 1'b1;
  int mismatch_cnt = 0;
  int words_sent = 0;
  int sets_sorted = 0;
  int sets_dropped = 0;
  int results_seen = 0;

  // Single-element sets come back unchanged; the rest goes to the predictor
  stim_row_t stim_table [TableLen] = '{
    '{MinVal, 1'b1, 1'b1, MinVal},
    '{MaxVal, 1'b1, 1'b1, MaxVal},
    '{32'sd0, 1'b1, 1'b1, 32'sd0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1},
    '{32'sd1, 1'b1, 1'b1, 32'sd1},
    // extremes mixed in one set
    '{MaxVal, 1'b0, 1'b0, '0},
    '{32'sd0, 1'b0, 1'b0, '0},
    '{MinVal, 1'b0, 1'b0, '0},
    '{-32'sd1, 1'b0, 1'b0, '0},
    '{32'sd1, 1'b1, 1'b0, '0},
    // equal values
    '{32'sd42, 1'b0, 1'b0, '0},
    '{32'sd42, 1'b0, 1'b0, '0},
    '{-32'sd3, 1'b0, 1'b0, '0},
    '{32'sd42, 1'b1, 1'b0, '0},
    // already ascending
    '{-32'sd2, 1'b0, 1'b0, '0},
    '{-32'sd1, 1'b0, 1'b0, '0},
    '{32'sd0, 1'b0, 1'b0, '0},
    '{32'sd1, 1'b0, 1'b0, '0},
    '{32'sd2, 1'b1, 1'b0, '0},
    // descending
    '{32'sd100, 1'b0, 1'b0, '0},
    '{32'sd50, 1'b0, 1'b0, '0},
    '{-32'sd50, 1'b1, 1'b0, '0}
  };

  heap_sort_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .is_last_i      (is_last_i),
    .valid_o        (valid_o),
    .sorted_value_o (sorted_value_o),
    .is_last_res_o  (is_last_res_o),
    .overflowed_o   (overflowed_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Sink one node of the max-heap held in the first heap_len entries
  function automatic void sink_down(int node, int heap_len);
    int                   lc;
    int                   rc;
    int                   top;
    bit                   done;
    logic signed [DW-1:0] t;
    done = 1'b0;
    while (!done) begin
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      top = node;
      if (lc < heap_len && word_store[lc] > word_store[top]) top = lc;
      if (rc < heap_len && word_store[rc] > word_store[top]) top = rc;
      if (top == node) begin
        done = 1'b1;
      end else begin
        t                = word_store[node];
        word_store[node] = word_store[top];
        word_store[top]  = t;
        node             = top;
      end
    end
  endfunction

  // Heapsort the loaded set and queue its words in ascending order
  function automatic void heapsort_and_queue();
    int                   n;
    int                   k;
    logic signed [DW-1:0] t;
    n = int'(fill_cnt);
    for (k = n / 2; k > 0; k--) sink_down(k - 1, n);
    for (k = n; k > 1; k--) begin
      t               = word_store[k - 1];
      word_store[k-1] = word_store[0];
      word_store[0]   = t;
      sink_down(0, k - 1);
    end
    for (k = 0; k < n; k++) begin
      sorted_q.push_back('{word_store[k], (k + 1 == n), drop_seen});
    end
  endfunction

  function automatic void check_field(string field, logic signed [DW-1:0] want_v,
                                      logic signed [DW-1:0] got_v);
    if (want_v !== got_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MaxReports)
        $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endfunction

  // Predict on every accepted word, then check the result strobe
  always @(posedge clk_i) begin : watch_engine
    sorted_word_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (fill_cnt < Capacity) begin
          word_store[fill_cnt] = value_i;
          fill_cnt             = fill_cnt + 1'b1;
        end else begin
          drop_seen = 1'b1;
        end
        if (is_last_i) begin
          sets_sorted++;
          if (drop_seen) sets_dropped++;
          if (typed_r) sorted_q.push_back('{typed_value_r, 1'b1, 1'b0});
          else heapsort_and_queue();
          fill_cnt  = '0;
          drop_seen = 1'b0;
        end
      end
      if (valid_o) begin
        results_seen++;
        if (sorted_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("%0t: no result expected, got sorted_value %0d last %0b overflow %0b",
                     $time, sorted_value_o, is_last_res_o, overflowed_o);
        end else begin
          want = sorted_q.pop_front();
          check_field("sorted_value", want.value, sorted_value_o);
          check_field("is_last_res", DW'(want.last), DW'(is_last_res_o));
          check_field("overflowed", DW'(want.dropped), DW'(overflowed_o));
        end
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until taken
  task automatic send_word(logic signed [DW-1:0] v, logic last, logic typed,
                           logic signed [DW-1:0] exp_v);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < 26) begin
      start_i   <= 1'b0;
      value_i   <= $urandom;
      is_last_i <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    value_i       <= v;
    is_last_i     <= last;
    typed_r       <= typed;
    typed_value_r <= exp_v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Extremes and small values show up often so duplicates and sign edges occur
  function automatic logic signed [DW-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return MinVal;
      end
      1: begin
        return MaxVal;
      end
      2: begin
        return $signed($urandom_range(0, 8)) - 4;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Drop start and hold off until every expected word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : run_stimulus
    int i;
    int k;
    int pick;
    int set_len;
    int set_no;
    int rand_words;
    int drain_cycles;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets
    for (i = 0; i < TableLen; i++) begin
      send_word(stim_table[i].value, stim_table[i].last, stim_table[i].typed,
                stim_table[i].exp_value);
    end
    wait_drained();

    // Random sets: first one overflows with a dropped last word, second fills exactly
    set_no     = 0;
    rand_words = 0;
    while (rand_words < RandWords) begin
      if (set_no == 0) begin
        set_len = Capacity + 2;
      end else if (set_no == 1) begin
        set_len = Capacity;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) set_len = $urandom_range(1, 8);
        else if (pick < 90) set_len = $urandom_range(9, 40);
        else if (pick < 95) set_len = Capacity;
        else set_len = $urandom_range(Capacity + 1, Capacity + 6);
      end
      for (k = 0; k < set_len; k++) begin
        idle_on = !(rand_words >= 150 && rand_words < 280);
        send_word(rand_value(), (k == set_len - 1), 1'b0, '0);
        rand_words++;
      end
      set_no++;
      if (set_no == 4 || $urandom_range(0, 9) == 0) wait_drained();
    end

    // Let the last set drain, then allow for stragglers
    @(negedge clk_i);
    start_i      <= 1'b0;
    drain_cycles = 0;
    while (sorted_q.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (sorted_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sorted_q.size());
      mismatch_cnt += sorted_q.size();
    end

    $display("Sent %0d words in %0d sets (%0d with dropped words), checked %0d results.",
             words_sent, sets_sorted, sets_dropped, results_seen);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #3000000;
    $display("%0t: run timed out", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_cell.sv
rtl/heap_sort_engine.sv
bench/heap_sort_engine_tb.sv
